### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/mpse_pkg.sv
// package: shared constants of the median pairwise slope estimator
package mpse_pkg;

  localparam int MAX_BANDS     = 16;
  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_W      = 16;
  localparam int SLOPE_W       = 25;
  localparam int BAND_W        = 5;

  localparam logic [BAND_W-1:0] BAND_RESET = 5'd16;

endpackage

### rtl/mpse_ram.sv
// generic single-write, single-read ram with registered read
module mpse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mpse_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module mpse_divider #(
  parameter int NW = 25,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [DW:0]     trial;
  logic            ge;
  logic [DW:0]     diff;

  always_comb begin
    trial = {rem, quotient[NW-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
        cnt      <= CNTW'(NW);
      end else if (busy) begin
        rem      <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quotient <= {quotient[NW-2:0], ge};
        cnt      <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/median_pairwise_slope_estimator.sv
// top level: median pairwise slope estimator
//
// usage
//   samples of one series enter on sample / sample_valid / sample_stall, one
//   item per accepted edge. after the effective band count of samples (2 to
//   MAX_BANDS) the block forms every pairwise slope into the slope ram, then
//   finds the median by counting, for each stored slope in turn, how many
//   slopes lie below and at or below it.
//   band_count is written on its own channel, always ready; the user must see
//   that it is written only while idle, as the block itself does not enforce it.
//   sequence
//   a sample that does not close a series is only stored. the closing sample is
//   followed by M = n(n-1)/2 pair steps, each through the serial divider, then
//   the median search, bound by the single read port of the slope ram.
//   sample_stall is high during that work.
//   the result is held in an output register; a stalled result holds, and
//   the block accepts the next series' samples while it waits.
//   reset clears the sample count and control, and band_count returns to 16.
module median_pairwise_slope_estimator #(
  parameter int MAX_BANDS     = mpse_pkg::MAX_BANDS,
  parameter int FRACTION_BITS = mpse_pkg::FRACTION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [mpse_pkg::SAMPLE_W-1:0] sample,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  output logic signed [mpse_pkg::SLOPE_W-1:0]  median_slope,
  output logic                               median_slope_valid,
  input  logic                               median_slope_stall,
  input  logic [mpse_pkg::BAND_W-1:0]          band_count,
  input  logic                               band_count_valid,
  output logic                               band_count_ready
);

  localparam int SW    = mpse_pkg::SAMPLE_W;
  localparam int OW    = mpse_pkg::SLOPE_W;
  localparam int AW    = $clog2(MAX_BANDS);
  localparam int CW    = $clog2(MAX_BANDS + 1);
  localparam int PAIRS = MAX_BANDS * (MAX_BANDS - 1) / 2;
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int MW    = $clog2(PAIRS + 1);
  localparam int NW    = SW + 1 + FRACTION_BITS;
  localparam int VW    = (NW + 1 > OW + 1) ? NW + 1 : OW + 1;
  localparam logic signed [VW-1:0] SMAX = VW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] SMIN = VW'(-(64'sd1 <<< (OW - 1)));

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_GEN_A = 11'b00000000010,
    S_GEN_B = 11'b00000000100,
    S_GEN_C = 11'b00000001000,
    S_DIV   = 11'b00000010000,
    S_WR    = 11'b00000100000,
    S_SEL_A = 11'b00001000000,
    S_SEL_B = 11'b00010000000,
    S_SCAN  = 11'b00100000000,
    S_CHECK = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;

  logic [mpse_pkg::BAND_W-1:0] bands;
  logic [CW-1:0]               n;
  logic [CW-1:0]               taken;
  logic [CW-1:0]               taken_next;
  logic [AW-1:0]               i;
  logic [AW-1:0]               j;
  logic [MW-1:0]               m;
  logic [MW-1:0]               c;
  logic [MW-1:0]               k;
  logic [MW-1:0]               less;
  logic [MW-1:0]               leq;
  logic                        pv;
  logic                        neg;
  logic signed [SW-1:0]        si;
  logic signed [OW-1:0]        cand;

  logic                        accept;
  logic [AW-1:0]               s_raddr;
  logic [SW-1:0]               s_rdata;
  logic                        s_we;
  logic [OW-1:0]               p_rdata;
  logic [PW-1:0]               p_raddr;
  logic [OW-1:0]               p_wdata;

  logic signed [SW:0]          diff;
  logic signed [NW-1:0]        num;
  logic [NW-1:0]               mag;
  logic                        div_start;
  logic                        div_done;
  logic [NW-1:0]               div_q;
  logic signed [VW-1:0]        sval;
  logic [MW-1:0]               t;

  assign band_count_ready = 1'b1;
  assign sample_stall     = (state != S_IDLE);
  assign accept           = sample_valid && !sample_stall;
  assign taken_next       = taken + CW'(1);
  assign s_we             = accept && (taken < CW'(MAX_BANDS));
  assign s_raddr          = (state == S_GEN_A) ? i : j;
  assign p_raddr          = (state == S_SEL_A) ? c[PW-1:0] : k[PW-1:0];
  assign div_start        = (state == S_GEN_C);
  assign t                = m >> 1;

  always_comb begin
    if (bands < 5'd2) begin
      n = CW'(2);
    end else if (32'(bands) > 32'(MAX_BANDS)) begin
      n = CW'(MAX_BANDS);
    end else begin
      n = CW'(bands);
    end
  end

  always_comb begin
    diff = $signed({s_rdata[SW-1], s_rdata}) - $signed({si[SW-1], si});
    num  = NW'(diff) <<< FRACTION_BITS;
    mag  = num[NW-1] ? NW'(-num) : NW'(num);
    sval = neg ? -$signed(VW'(div_q)) : $signed(VW'(div_q));
    if (sval > SMAX) begin
      p_wdata = SMAX[OW-1:0];
    end else if (sval < SMIN) begin
      p_wdata = SMIN[OW-1:0];
    end else begin
      p_wdata = sval[OW-1:0];
    end
  end

  mpse_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_BANDS)
  ) u_sample_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(taken[AW-1:0]),
    .wdata(sample),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  mpse_ram #(
    .WIDTH(OW),
    .DEPTH(PAIRS)
  ) u_slope_ram (
    .clk  (clk),
    .we   (state == S_WR),
    .waddr(m[PW-1:0]),
    .wdata(p_wdata),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  mpse_divider #(
    .NW(NW),
    .DW(AW)
  ) u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mag),
    .divisor (j - i),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bands <= mpse_pkg::BAND_RESET;
    end else if (band_count_valid && band_count_ready) begin
      bands <= band_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      taken              <= '0;
      median_slope_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!median_slope_valid || !median_slope_stall)) begin
        median_slope_valid <= 1'b1;
      end else if (median_slope_valid && !median_slope_stall) begin
        median_slope_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (taken_next >= n) begin
              taken <= '0;
              i     <= '0;
              j     <= AW'(1);
              m     <= '0;
              state <= S_GEN_A;
            end else begin
              taken <= taken_next;
            end
          end
        end
        S_GEN_A: begin
          state <= S_GEN_B;
        end
        S_GEN_B: begin
          si    <= s_rdata;
          state <= S_GEN_C;
        end
        S_GEN_C: begin
          neg   <= num[NW-1];
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: begin
          m     <= m + MW'(1);
          state <= S_GEN_A;
          if (CW'(j) == n - CW'(1)) begin
            if (CW'(i) + CW'(2) >= n) begin
              c     <= '0;
              state <= S_SEL_A;
            end else begin
              i <= i + AW'(1);
              j <= i + AW'(2);
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        S_SEL_A: begin
          state <= S_SEL_B;
        end
        S_SEL_B: begin
          cand  <= p_rdata;
          k     <= '0;
          less  <= '0;
          leq   <= '0;
          pv    <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          pv <= (k < m);
          k  <= k + MW'(1);
          if (pv) begin
            if ($signed(p_rdata) < cand) begin
              less <= less + MW'(1);
            end
            if ($signed(p_rdata) <= cand) begin
              leq <= leq + MW'(1);
            end
            if (k == m) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (less <= t && t < leq) begin
            state <= S_DONE;
          end else begin
            c     <= c + MW'(1);
            state <= S_SEL_A;
          end
        end
        S_DONE: begin
          if (!median_slope_valid || !median_slope_stall) begin
            median_slope <= cand;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/mpse_checker.sv
// port-level checker for the median pairwise slope estimator, with its bind
`include "assert_macros.svh"

module mpse_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sample_valid,
  input logic                               sample_stall,
  input logic signed [mpse_pkg::SLOPE_W-1:0]  median_slope,
  input logic                               median_slope_valid,
  input logic                               median_slope_stall,
  input logic                               band_count_valid,
  input logic                               band_count_ready
);

  // a stalled result keeps its value
  `ASSERT_NEXT(a_out_hold, median_slope_valid && median_slope_stall,
               median_slope_valid && $stable(median_slope))

  // a new result only comes out of the compute phase, with input stalled
  `ASSERT_IMPLIES(a_rise_after_work, $rose(median_slope_valid), $past(sample_stall))

  // no result in the cycle right after an accepted item
  `ASSERT_IMPLIES(a_no_instant_result, $rose(median_slope_valid),
                  !$past(sample_valid && !sample_stall))

  // configuration is never refused
  `ASSERT_IMPLIES(a_cfg_ready, band_count_valid, band_count_ready)

endmodule

bind median_pairwise_slope_estimator mpse_checker u_mpse_checker (.*);

### tb/median_pairwise_slope_estimator_tb.sv
// testbench for the median pairwise slope estimator: random and directed series, scoreboard check
`timescale 1ns / 1ps

module median_pairwise_slope_estimator_tb;

  localparam int SAMPLE_W      = mpse_pkg::SAMPLE_W;
  localparam int SLOPE_W       = mpse_pkg::SLOPE_W;
  localparam int BAND_W        = mpse_pkg::BAND_W;
  localparam int MAX_BANDS     = mpse_pkg::MAX_BANDS;
  localparam int FRACTION_BITS = mpse_pkg::FRACTION_BITS;
  localparam logic [BAND_W-1:0] BAND_RESET = mpse_pkg::BAND_RESET;

  localparam int CFG_INDEX   = 0;
  localparam int WATCHDOG    = 200000;
  localparam int DRAIN_WAIT  = 64;
  localparam int ITEM_TARGET = 1650;

  logic clk;
  logic rst;
  logic signed [SAMPLE_W-1:0] sample;
  logic sample_valid;
  logic sample_stall;
  logic signed [SLOPE_W-1:0] median_slope;
  logic median_slope_valid;
  logic median_slope_stall;
  logic [BAND_W-1:0] band_count;
  logic band_count_valid;
  logic band_count_ready;

  median_pairwise_slope_estimator dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .median_slope(median_slope),
    .median_slope_valid(median_slope_valid),
    .median_slope_stall(median_slope_stall),
    .band_count(band_count),
    .band_count_valid(band_count_valid),
    .band_count_ready(band_count_ready)
  );

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  logic signed [SLOPE_W-1:0] expected_medians[$];

  logic signed [SAMPLE_W-1:0] series_store[MAX_BANDS];
  int unsigned series_len;
  logic [BAND_W-1:0] bands_reg;
  int errors;
  int idle_cycles;
  int items_sent;
  bit sample_taken;
  bit idling_on;
  int gap_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // theil-sen median of the series held so far
  function automatic logic signed [SLOPE_W-1:0] series_median(int unsigned n);
    longint slopes[$];
    longint v;
    int k;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        v = ((longint'(series_store[j]) - longint'(series_store[i])) *
             (longint'(1) << FRACTION_BITS)) / longint'(j - i);
        if (v > 64'sd16777215) v = 64'sd16777215;
        if (v < -64'sd16777216) v = -64'sd16777216;
        k = slopes.size();
        slopes.push_back(v);
        while (k > 0 && slopes[k-1] > v) begin
          slopes[k] = slopes[k-1];
          k--;
        end
        slopes[k] = v;
      end
    end
    return SLOPE_W'(slopes[slopes.size() / 2]);
  endfunction

  function automatic void take_sample(logic signed [SAMPLE_W-1:0] s);
    int unsigned n;
    n = 32'(bands_reg);
    if (n < 2) n = 2;
    if (n > MAX_BANDS) n = MAX_BANDS;
    if (series_len < MAX_BANDS) series_store[series_len] = s;
    series_len++;
    if (series_len >= n) begin
      expected_medians.push_back(series_median(n));
      series_len = 0;
    end
  endfunction

  // monitor, predictor and scoreboard
  always @(posedge clk) begin
    sample_taken = 1'b0;
    if (rst) begin
      series_len = 0;
      bands_reg = BAND_RESET;
      idle_cycles = 0;
      errors = 0;
    end else begin
      idle_cycles++;
      if (band_count_valid && band_count_ready) begin
        bands_reg = band_count;
        idle_cycles = 0;
      end
      if (sample_valid && !sample_stall) begin
        take_sample(sample);
        sample_taken = 1'b1;
        idle_cycles = 0;
      end
      if (median_slope_valid && !median_slope_stall) begin
        idle_cycles = 0;
        if (expected_medians.size() == 0) begin
          $error("median_slope: unexpected item %0d", median_slope);
          errors++;
        end else begin
          if (median_slope !== expected_medians[0]) begin
            $error("median_slope: expected %0d actual %0d",
                   expected_medians[0], median_slope);
            errors++;
          end
          void'(expected_medians.pop_front());
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("median_pairwise_slope_estimator verification failed");
        $finish;
      end
    end
  end

  // sample driver and result stall
  always @(negedge clk) begin
    logic nxt_valid;
    logic signed [SAMPLE_W-1:0] nxt_sample;
    nxt_valid = sample_valid;
    nxt_sample = sample;
    if (rst) begin
      nxt_valid = 1'b0;
      nxt_sample = '0;
      gap_left = 0;
      stall_left = 0;
      median_slope_stall <= 1'b0;
    end else begin
      if (sample_valid && sample_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0) begin
          nxt_sample = pending_samples.pop_front();
          nxt_valid = 1'b1;
          gap_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        median_slope_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        median_slope_stall <= 1'b0;
      end
    end
    sample_valid <= nxt_valid;
    sample <= nxt_sample;
  end

  task automatic write_bands(logic [BAND_W-1:0] value);
    @(negedge clk);
    band_count <= value;
    band_count_valid <= 1'b1;
    @(posedge clk);
    while (!band_count_ready) @(posedge clk);
    @(negedge clk);
    band_count_valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_samples.size() > 0 || sample_valid || expected_medians.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_sample(logic signed [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    items_sent++;
  endtask

  function automatic logic [BAND_W-1:0] pick_bands();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return BAND_W'($urandom_range(2, 4));
    if (r < 80) return BAND_W'($urandom_range(5, 8));
    if (r < 88) return BAND_W'($urandom_range(0, 1));
    if (r < 97) return BAND_W'($urandom_range(9, 15));
    return BAND_W'($urandom_range(16, 31));
  endfunction

  task automatic queue_series(int unsigned cnt);
    int mode;
    int base;
    int step;
    mode = $urandom_range(0, 5);
    base = $urandom_range(0, 65535) - 32768;
    step = $urandom_range(0, 2000) - 1000;
    for (int i = 0; i < cnt; i++) begin
      case (mode)
        0, 1: queue_sample(SAMPLE_W'($urandom_range(0, 65535)));
        2: queue_sample(SAMPLE_W'($urandom_range(0, 40) - 20));
        3: queue_sample(SAMPLE_W'(base));
        4: queue_sample(SAMPLE_W'(base + step * i + $urandom_range(0, 8)));
        default: queue_sample($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      endcase
    end
  endtask

  initial begin
    int unsigned n;
    rst = 1'b1;
    band_count = BAND_RESET;
    band_count_valid = 1'b0;
    items_sent = 0;
    idling_on = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset band count, extremes alternating
    for (int i = 0; i < 16; i++) queue_sample(i[0] ? 16'sh7fff : 16'sh8000);
    drain();
    write_bands(5'd2);
    queue_sample(16'sh8000); queue_sample(16'sh7fff);
    queue_sample(16'sh7fff); queue_sample(16'sh8000);
    drain();
    write_bands(5'd0);
    queue_sample(16'sd5); queue_sample(-16'sd3);
    drain();
    write_bands(5'd31);
    queue_series(16);
    drain();
    // band count lowered mid series
    write_bands(5'd8);
    for (int i = 0; i < 5; i++) queue_sample(SAMPLE_W'(i * 7 - 11));
    drain();
    write_bands(5'd3);
    queue_sample(16'sd100);
    drain();

    idling_on = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      idling_on = ($urandom_range(0, 3) != 0);
      write_bands(pick_bands());
      n = 32'(bands_reg);
      if (n < 2) n = 2;
      if (n > MAX_BANDS) n = MAX_BANDS;
      for (int s = $urandom_range(1, n > 8 ? 2 : 6); s > 0; s--) queue_series(n);
      if ($urandom_range(0, 3) == 0) queue_series($urandom_range(1, n - 1));
      drain();
    end

    if (errors == 0) begin
      $display("median_pairwise_slope_estimator verification clean");
    end else begin
      $display("median_pairwise_slope_estimator verification failed");
    end
    $finish;
  end
endmodule
